/* design/alrm_pkg.sv */
// Package for the ARINC 429 label rate monitor.
// Holds shared types, register indexes, reset values and the monitored-label table.
// No dependencies; compiled first.
package alrm_pkg;

    localparam int LABEL_BITS     = 8;
    localparam int LABEL_SPACE    = 256;
    localparam int TABLE_LEN      = 32;
    localparam int TABLE_IDX_BITS = 5;
    localparam int CFG_IDX_BITS   = 8;
    localparam int CFG_DATA_BITS  = 8;
    localparam int OBS_BITS       = 16;
    localparam int EXP_BITS       = 6;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SYNC_LABEL       = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SYNCS_PER_WINDOW = 8'd1;

    // Register reset values
    localparam logic [LABEL_BITS-1:0]    SYNC_LABEL_RST       = 8'o351;
    localparam logic [CFG_DATA_BITS-1:0] SYNCS_PER_WINDOW_RST = 8'd2;

    // Classified word handed from front to back
    typedef struct packed {
        logic [LABEL_BITS-1:0] label;
        logic                  close;
    } cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_INC_WR,
        B_RPT_RD,
        B_RPT_OUT
    } back_state_t;

    // Monitored label for each report slot
    function automatic logic [LABEL_BITS-1:0] mon_label(input logic [TABLE_IDX_BITS-1:0] idx);
        logic [LABEL_BITS-1:0] lbl;
        case (idx)
            5'd0:    lbl = 8'o265;
            5'd1:    lbl = 8'o324;
            5'd2:    lbl = 8'o325;
            5'd3:    lbl = 8'o326;
            5'd4:    lbl = 8'o327;
            5'd5:    lbl = 8'o330;
            5'd6:    lbl = 8'o331;
            5'd7:    lbl = 8'o332;
            5'd8:    lbl = 8'o333;
            5'd9:    lbl = 8'o335;
            5'd10:   lbl = 8'o336;
            5'd11:   lbl = 8'o337;
            5'd12:   lbl = 8'o360;
            5'd13:   lbl = 8'o364;
            5'd14:   lbl = 8'o313;
            5'd15:   lbl = 8'o365;
            5'd16:   lbl = 8'o361;
            5'd17:   lbl = 8'o321;
            5'd18:   lbl = 8'o314;
            5'd19:   lbl = 8'o312;
            5'd20:   lbl = 8'o315;
            5'd21:   lbl = 8'o316;
            5'd22:   lbl = 8'o366;
            5'd23:   lbl = 8'o367;
            5'd24:   lbl = 8'o334;
            5'd25:   lbl = 8'o310;
            5'd26:   lbl = 8'o311;
            5'd27:   lbl = 8'o370;
            5'd28:   lbl = 8'o350;
            5'd29:   lbl = 8'o270;
            5'd30:   lbl = 8'o371;
            5'd31:   lbl = 8'o351;
            default: lbl = 8'o351;
        endcase
        return lbl;
    endfunction

    // Expected words per window for each report slot
    function automatic logic [EXP_BITS-1:0] mon_expected(input logic [TABLE_IDX_BITS-1:0] idx);
        logic [EXP_BITS-1:0] exp_cnt;
        if (idx <= 5'd13) begin
            exp_cnt = 6'd50;
        end else if (idx <= 5'd18) begin
            exp_cnt = 6'd25;
        end else if (idx <= 5'd24) begin
            exp_cnt = 6'd10;
        end else if (idx <= 5'd27) begin
            exp_cnt = 6'd5;
        end else begin
            exp_cnt = 6'd2;
        end
        return exp_cnt;
    endfunction

endpackage

/* design/alrm_ifs.sv */
// Channel interfaces for the label rate monitor: word input, report output, config writes.
// Depends on alrm_pkg for field widths.
interface alrm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] rx_word;

    modport source (output valid, output rx_word, input ready);
    modport sink   (input valid, input rx_word, output ready);
endinterface

interface alrm_out_if;
    logic                           valid;
    logic                           ready;
    logic [alrm_pkg::LABEL_BITS-1:0] report_label;
    logic [alrm_pkg::OBS_BITS-1:0]   observed_count;
    logic [alrm_pkg::EXP_BITS-1:0]   expected_count;
    logic                           rate_mismatch;
    logic                           last_of_report;

    modport source (output valid, output report_label, output observed_count,
                    output expected_count, output rate_mismatch, output last_of_report,
                    input ready);
    modport sink   (input valid, input report_label, input observed_count,
                    input expected_count, input rate_mismatch, input last_of_report,
                    output ready);
endinterface

interface alrm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [alrm_pkg::CFG_IDX_BITS-1:0]  index;
    logic [alrm_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/alrm_front.sv */
// Front end: config registers, alignment and sync-phase tracking, word classification.
// Depends on alrm_pkg and alrm_ifs; pushes classified words into the command queue.
module alrm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    alrm_in_if.sink              rx,
    alrm_cfg_if.sink             cfg,
    input  alrm_pkg::fifo_stat_t fifo_stat,
    output logic                 push,
    output alrm_pkg::cmd_t       cmd
);

    logic                                sync_label_reg;
    logic [alrm_pkg::LABEL_BITS-1:0]     sync_lbl_reg;
    logic [alrm_pkg::CFG_DATA_BITS-1:0]  spw_reg;
    logic                                aligned_reg;
    logic                                aligned_next;
    logic [alrm_pkg::CFG_DATA_BITS-1:0]  phase_reg;
    logic [alrm_pkg::CFG_DATA_BITS-1:0]  phase_next;
    logic [alrm_pkg::LABEL_BITS-1:0]     lbl;
    logic                                is_sync;
    logic                                closes;
    logic                                accept;
    logic [alrm_pkg::CFG_DATA_BITS:0]    phase_inc;

    assign rx.ready  = !fifo_stat.full;
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;

    // Classify the incoming beat
    assign lbl       = rx.rx_word[alrm_pkg::LABEL_BITS-1:0];
    assign is_sync   = (lbl == sync_lbl_reg);
    assign phase_inc = {1'b0, phase_reg} + 9'd1;
    assign closes    = is_sync && (phase_inc >= {1'b0, spw_reg});

    assign push      = accept && aligned_reg;
    assign cmd.label = lbl;
    assign cmd.close = closes;

    // Alignment and phase update
    always_comb
    begin
        aligned_next = aligned_reg;
        phase_next   = phase_reg;
        if (accept) begin
            if (!aligned_reg) begin
                if (is_sync) begin
                    aligned_next = 1'b1;
                end
            end else if (is_sync) begin
                phase_next = closes ? '0 : phase_inc[alrm_pkg::CFG_DATA_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            aligned_reg <= 1'b0;
            phase_reg   <= '0;
        end else begin
            aligned_reg <= aligned_next;
            phase_reg   <= phase_next;
        end
    end

    // Config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sync_lbl_reg <= alrm_pkg::SYNC_LABEL_RST;
            spw_reg      <= alrm_pkg::SYNCS_PER_WINDOW_RST;
        end else if (cfg.valid && cfg.ready) begin
            case (cfg.index)
                alrm_pkg::CFG_IDX_SYNC_LABEL:       sync_lbl_reg <= cfg.data;
                alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW: spw_reg      <= cfg.data;
                default: ;
            endcase
        end
    end

    // sync_label_reg marks a pending sync beat; kept for debug visibility
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sync_label_reg <= 1'b0;
        end else begin
            sync_label_reg <= accept && is_sync;
        end
    end

`ifndef SYNTH
    // A beat that closes a window is always a sync beat
    assert property (@(posedge clk) disable iff (!rst_n) closes |-> is_sync)
        else $error("close flagged on non-sync label");
    // A queued window close clears the phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.close) |=> (phase_reg == '0))
        else $error("phase not cleared at window close");
    // Nothing is queued before alignment
    assert property (@(posedge clk) disable iff (!rst_n) push |-> aligned_reg)
        else $error("push before alignment");
    // Sync beat during alignment sets the aligned flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (sync_label_reg && !$past(aligned_reg)) |-> aligned_reg)
        else $error("alignment not taken");
`endif

endmodule

/* design/alrm_cmd_fifo.sv */
// Short command queue between front end and back end.
// Depends on alrm_pkg for cmd_t, fifo_stat_t and the depth.
module alrm_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  alrm_pkg::cmd_t       cmd_in,
    input  logic                 pop,
    output alrm_pkg::cmd_t       cmd_out,
    output alrm_pkg::fifo_stat_t stat
);

    alrm_pkg::cmd_t                    entry_reg [alrm_pkg::FIFO_DEPTH];
    logic [alrm_pkg::FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [alrm_pkg::FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [alrm_pkg::FIFO_PTR_BITS:0]   count_reg;
    logic [alrm_pkg::FIFO_PTR_BITS:0]   count_next;
    logic                               do_push;
    logic                               do_pop;

    assign stat.full  = (count_reg == (alrm_pkg::FIFO_PTR_BITS+1)'(alrm_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign cmd_out    = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* design/alrm_back.sv */
// Back end: per-label counter memory with valid bits, saturating increment and report sweep.
// Depends on alrm_pkg and alrm_ifs; pops commands from the queue, drives the report channel.
module alrm_back #(
    parameter int COUNT_BITS       = 16,
    parameter int MONITORED_LABELS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alrm_pkg::fifo_stat_t fifo_stat,
    input  alrm_pkg::cmd_t       cmd,
    output logic                 pop,
    alrm_out_if.source           report
);

    localparam int REPORT_LEN = (MONITORED_LABELS < alrm_pkg::TABLE_LEN) ?
                                MONITORED_LABELS : alrm_pkg::TABLE_LEN;
    localparam int KW         = (REPORT_LEN > 1) ? $clog2(REPORT_LEN) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(REPORT_LEN - 1);
    localparam int WB         = (COUNT_BITS > alrm_pkg::OBS_BITS) ?
                                COUNT_BITS : alrm_pkg::OBS_BITS;

    alrm_pkg::back_state_t state_reg;
    alrm_pkg::back_state_t state_next;

    logic [COUNT_BITS-1:0]                cnt_mem [alrm_pkg::LABEL_SPACE];
    logic [alrm_pkg::LABEL_SPACE-1:0]     valid_reg;
    logic [COUNT_BITS-1:0]                rd_data_reg;
    logic                                 rd_hit_reg;
    logic [alrm_pkg::LABEL_BITS-1:0]      label_reg;
    logic                                 close_reg;
    logic [KW-1:0]                        k_reg;

    logic                                 out_valid_reg;
    logic [alrm_pkg::LABEL_BITS-1:0]      out_label_reg;
    logic [alrm_pkg::OBS_BITS-1:0]        out_obs_reg;
    logic [alrm_pkg::EXP_BITS-1:0]        out_exp_reg;
    logic                                 out_mis_reg;
    logic                                 out_last_reg;

    logic                                 rd_en;
    logic [alrm_pkg::LABEL_BITS-1:0]      rd_addr;
    logic                                 wr_en;
    logic                                 slot_free;
    logic                                 load_out;
    logic                                 clear_all;
    logic [alrm_pkg::TABLE_IDX_BITS-1:0]  tbl_idx;
    logic [COUNT_BITS-1:0]                cur_cnt;
    logic [COUNT_BITS-1:0]                inc_cnt;
    logic [WB-1:0]                        cur_wide;
    logic [alrm_pkg::OBS_BITS-1:0]        obs;
    logic [alrm_pkg::EXP_BITS-1:0]        exp_cnt;

    // Count as read back, with unwritten entries reading zero
    assign tbl_idx  = alrm_pkg::TABLE_IDX_BITS'(k_reg);
    assign cur_cnt  = rd_hit_reg ? rd_data_reg : '0;
    assign inc_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
    assign cur_wide = WB'(cur_cnt);
    assign obs      = (cur_wide > WB'(16'hFFFF)) ? 16'hFFFF : cur_wide[alrm_pkg::OBS_BITS-1:0];
    assign exp_cnt  = alrm_pkg::mon_expected(tbl_idx);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alrm_pkg::B_IDLE:
                if (!fifo_stat.empty) begin
                    state_next = alrm_pkg::B_INC_WR;
                end
            alrm_pkg::B_INC_WR:
                state_next = close_reg ? alrm_pkg::B_RPT_RD : alrm_pkg::B_IDLE;
            alrm_pkg::B_RPT_RD:
                state_next = alrm_pkg::B_RPT_OUT;
            alrm_pkg::B_RPT_OUT:
                if (load_out) begin
                    state_next = (k_reg == K_LAST) ? alrm_pkg::B_IDLE : alrm_pkg::B_RPT_RD;
                end
            default:
                state_next = alrm_pkg::B_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = cmd.label;
        wr_en     = 1'b0;
        load_out  = 1'b0;
        clear_all = 1'b0;
        slot_free = !out_valid_reg || report.ready;
        case (state_reg)
            alrm_pkg::B_IDLE:
            begin
                pop   = !fifo_stat.empty;
                rd_en = !fifo_stat.empty;
            end
            alrm_pkg::B_INC_WR:
                wr_en = 1'b1;
            alrm_pkg::B_RPT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = alrm_pkg::mon_label(tbl_idx);
            end
            alrm_pkg::B_RPT_OUT:
            begin
                load_out  = slot_free;
                clear_all = slot_free && (k_reg == K_LAST);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= alrm_pkg::B_IDLE;
            k_reg         <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                k_reg <= (k_reg == K_LAST) ? '0 : k_reg + 1'b1;
            end
            if (clear_all) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[label_reg] <= 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (report.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command hold
    always_ff @(posedge clk)
    begin
        if (pop) begin
            label_reg <= cmd.label;
            close_reg <= cmd.close;
        end
    end

    // Counter memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            cnt_mem[label_reg] <= inc_cnt;
        end
        if (rd_en) begin
            rd_data_reg <= cnt_mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr];
        end
    end

    // Report output register
    always_ff @(posedge clk)
    begin
        if (load_out) begin
            out_label_reg <= alrm_pkg::mon_label(tbl_idx);
            out_obs_reg   <= obs;
            out_exp_reg   <= exp_cnt;
            out_mis_reg   <= (obs != {{(alrm_pkg::OBS_BITS-alrm_pkg::EXP_BITS){1'b0}}, exp_cnt});
            out_last_reg  <= (k_reg == K_LAST);
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.report_label   = out_label_reg;
    assign report.observed_count = out_obs_reg;
    assign report.expected_count = out_exp_reg;
    assign report.rate_mismatch  = out_mis_reg;
    assign report.last_of_report = out_last_reg;

`ifndef SYNTH
    // Memory write and read never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !rd_en)
        else $error("counter memory read/write collision");
    // Every increment follows a queue pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alrm_pkg::B_INC_WR) |-> $past(pop))
        else $error("increment without a popped command");
    // Store is empty after the last report beat is loaded
    assert property (@(posedge clk) disable iff (!rst_n) clear_all |=> (valid_reg == '0))
        else $error("counters not cleared after report");
    // A report beat is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || report.ready))
        else $error("report beat overwritten");
`endif

endmodule

/* design/arinc_label_rate_monitor_top.sv */
// Top level of the ARINC 429 label rate monitor.
// Depends on alrm_pkg, alrm_ifs, alrm_front, alrm_cmd_fifo and alrm_back.
//
// Usage:
//   rx     : received ARINC 429 words, one per beat, label in bits 7..0.
//   report : one beat per monitored label when a window closes, in table order,
//            last_of_report set on the final beat.
//   cfg    : register writes (index 0 sync label, 1 syncs per window), always ready;
//            write only while the block is idle.
// Throughput: the front takes a word each cycle while the four-entry command
//   queue has room; the back pops each counted word with a counter memory read
//   and writes it back before it pops the next word.
// Reporting: a closing sync word reaches the back after the words queued ahead of it;
//   once it is popped its counter is written back, then each report beat takes a
//   table read and an output load, for up to 32 beats; no word is popped during
//   this report sweep, and input stays ready while the queue has room.
// Reset: asynchronous, active low; clears alignment, phase, queue, and the per-label
//   valid bits, so every counter reads zero at once with no clearing pass.
// Stall: a report beat holds in the output register until taken; the sweep waits,
//   the queue fills and then rx.ready drops.
module arinc_label_rate_monitor_top #(
    parameter int COUNT_BITS       = 16,
    parameter int MONITORED_LABELS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    alrm_in_if.sink     rx,
    alrm_out_if.source  report,
    alrm_cfg_if.sink    cfg
);

    alrm_pkg::fifo_stat_t fifo_stat;
    alrm_pkg::cmd_t       push_cmd;
    alrm_pkg::cmd_t       pop_cmd;
    logic                 push;
    logic                 pop;

    alrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .fifo_stat (fifo_stat),
        .push      (push),
        .cmd       (push_cmd)
    );

    alrm_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (push_cmd),
        .pop     (pop),
        .cmd_out (pop_cmd),
        .stat    (fifo_stat)
    );

    alrm_back #(
        .COUNT_BITS       (COUNT_BITS),
        .MONITORED_LABELS (MONITORED_LABELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .cmd       (pop_cmd),
        .pop       (pop),
        .report    (report)
    );

endmodule

/* tb/tb_arinc_label_rate_monitor_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for arinc_label_rate_monitor_top: directed table, back-to-back
// burst and random windows, all checked beat by beat against a label counter model.
// Depends on alrm_pkg, alrm_ifs and the design files under design/.
module tb_arinc_label_rate_monitor_top;

    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AT_BEAT    = 160;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int BURST_WORDS     = 12;
    localparam int NUM_PHASES      = 6;
    localparam int WORDS_PER_PHASE = 50;

    localparam logic [alrm_pkg::CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 8'hFF;
    localparam logic [alrm_pkg::OBS_BITS-1:0]     COUNT_SAT      = 16'hFFFF;
    localparam logic [7:0]                        STALL_PAT      = 8'b1011_0010;

    // Monitored labels and their expected rates, report order
    localparam logic [0:alrm_pkg::TABLE_LEN-1][alrm_pkg::LABEL_BITS-1:0] WATCH_LBL = {
        8'o265, 8'o324, 8'o325, 8'o326, 8'o327, 8'o330, 8'o331, 8'o332,
        8'o333, 8'o335, 8'o336, 8'o337, 8'o360, 8'o364,
        8'o313, 8'o365, 8'o361, 8'o321, 8'o314,
        8'o312, 8'o315, 8'o316, 8'o366, 8'o367, 8'o334,
        8'o310, 8'o311, 8'o370,
        8'o350, 8'o270, 8'o371, 8'o351
    };
    localparam logic [0:alrm_pkg::TABLE_LEN-1][alrm_pkg::EXP_BITS-1:0] WATCH_RATE = {
        {14{6'd50}}, {5{6'd25}}, {6{6'd10}}, {3{6'd5}}, {4{6'd2}}
    };

    typedef struct {
        logic [alrm_pkg::LABEL_BITS-1:0] report_label;
        logic [alrm_pkg::OBS_BITS-1:0]   observed_count;
        logic [alrm_pkg::EXP_BITS-1:0]   expected_count;
        logic                            rate_mismatch;
        logic                            last_of_report;
    } rate_beat_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        logic [31:0]                        word;
        logic [alrm_pkg::CFG_IDX_BITS-1:0]  idx;
        logic [alrm_pkg::CFG_DATA_BITS-1:0] data;
        bit                                 typed;
        logic [alrm_pkg::OBS_BITS-1:0]      sync_obs;
    } dir_row_t;

    logic clk;
    logic rst_n;

    alrm_in_if  rx_if();
    alrm_out_if rpt_if();
    alrm_cfg_if cfg_if();

    arinc_label_rate_monitor_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .report (rpt_if),
        .cfg    (cfg_if)
    );

    // Label counter model state
    logic [alrm_pkg::OBS_BITS-1:0]      lbl_count [alrm_pkg::LABEL_SPACE];
    bit                                 aligned;
    logic [7:0]                         win_phase;
    logic [alrm_pkg::LABEL_BITS-1:0]    cur_sync;
    logic [alrm_pkg::CFG_DATA_BITS-1:0] cur_spw;

    rate_beat_t report_q [$];
    dir_row_t   dir_rows [$];
    int         bad_beats;
    int         beats_taken;
    int         idle_cycles;
    int         burst_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Model of one accepted word; queues the report of a closing sync word
    task automatic count_word(input logic [31:0] w);
        logic [alrm_pkg::LABEL_BITS-1:0] lbl;
        rate_beat_t                      b;
        lbl = w[7:0];
        if (!aligned)
        begin
            if (lbl == cur_sync)
                aligned = 1'b1;
            return;
        end
        if (lbl_count[lbl] != COUNT_SAT)
            lbl_count[lbl] = lbl_count[lbl] + 1'b1;
        if (lbl != cur_sync)
            return;
        if ({1'b0, win_phase} + 9'd1 < {1'b0, cur_spw})
        begin
            win_phase = win_phase + 1'b1;
            return;
        end
        win_phase = '0;
        for (int k = 0; k < alrm_pkg::TABLE_LEN; k++)
        begin
            b.report_label   = WATCH_LBL[k];
            b.observed_count = lbl_count[WATCH_LBL[k]];
            b.expected_count = WATCH_RATE[k];
            b.rate_mismatch  = (b.observed_count != {10'd0, WATCH_RATE[k]});
            b.last_of_report = (k == alrm_pkg::TABLE_LEN - 1);
            report_q.push_back(b);
        end
        for (int i = 0; i < alrm_pkg::LABEL_SPACE; i++)
            lbl_count[i] = '0;
    endtask

    // Offer one word from a falling edge; returns at the falling edge after the beat
    task automatic send_word(input logic [31:0] w);
        rx_if.valid   <= 1'b1;
        rx_if.rx_word <= w;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        count_word(w);
        @(negedge clk);
    endtask

    // Burst pacing of the sender
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop sending, wait for every queued report and let in-flight words settle
    task automatic drain();
        rx_if.valid <= 1'b0;
        @(negedge clk);
        while (report_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [alrm_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [alrm_pkg::CFG_DATA_BITS-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx == alrm_pkg::CFG_IDX_SYNC_LABEL)
            cur_sync = val;
        else if (idx == alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW)
            cur_spw = val;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic add_word(input logic [31:0] w);
        dir_row_t r;
        r = '{ROW_WORD, w, '0, '0, 1'b0, '0};
        dir_rows.push_back(r);
    endtask

    // Closing sync word whose count for label 0351 is known by inspection
    task automatic add_close(input logic [31:0] w, input logic [alrm_pkg::OBS_BITS-1:0] obs);
        dir_row_t r;
        r = '{ROW_WORD, w, '0, '0, 1'b1, obs};
        dir_rows.push_back(r);
    endtask

    task automatic add_cfg(input logic [alrm_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [alrm_pkg::CFG_DATA_BITS-1:0] val);
        dir_row_t r;
        r = '{ROW_CFG, '0, idx, val, 1'b0, '0};
        dir_rows.push_back(r);
    endtask

    // Receiver: stall modes, plus one long hold once reports are flowing
    initial
    begin
        int         hold_left;
        int         mode;
        int         mode_left;
        logic [2:0] pat_pos;
        bit         hold_done;
        hold_left    = 0;
        mode         = 0;
        mode_left    = 0;
        pat_pos      = '0;
        hold_done    = 1'b0;
        rpt_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && beats_taken >= HOLD_AT_BEAT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rpt_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    0:       rpt_if.ready <= 1'b1;
                    1:       rpt_if.ready <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        rpt_if.ready <= STALL_PAT[pat_pos];
                        pat_pos = pat_pos + 1'b1;
                    end
                endcase
            end
        end
    end

    // Report checker
    always @(posedge clk)
    begin : check_beats
        rate_beat_t want;
        if (rst_n && rpt_if.valid && rpt_if.ready)
        begin
            beats_taken++;
            if (report_q.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("%0t: unexpected report beat label %o obs %0d",
                             $realtime, rpt_if.report_label, rpt_if.observed_count);
            end
            else
            begin
                want = report_q.pop_front();
                if (rpt_if.report_label   !== want.report_label   ||
                    rpt_if.observed_count !== want.observed_count ||
                    rpt_if.expected_count !== want.expected_count ||
                    rpt_if.rate_mismatch  !== want.rate_mismatch  ||
                    rpt_if.last_of_report !== want.last_of_report)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("%0t: beat mismatch exp lbl %o obs %0d exp %0d mis %b last %b",
                                 $realtime, want.report_label, want.observed_count,
                                 want.expected_count, want.rate_mismatch, want.last_of_report,
                                 ", got lbl %o obs %0d exp %0d mis %b last %b",
                                 rpt_if.report_label, rpt_if.observed_count,
                                 rpt_if.expected_count, rpt_if.rate_mismatch,
                                 rpt_if.last_of_report);
                end
            end
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (rpt_if.valid && rpt_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        rate_beat_t                      b;
        bit                              prev_word;
        int                              r;
        logic [31:0]                     w;
        logic [alrm_pkg::LABEL_BITS-1:0] lbl;

        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_word = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        bad_beats     = 0;
        beats_taken   = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        for (int i = 0; i < alrm_pkg::LABEL_SPACE; i++)
            lbl_count[i] = '0;
        aligned   = 1'b0;
        win_phase = '0;
        cur_sync  = alrm_pkg::SYNC_LABEL_RST;
        cur_spw   = alrm_pkg::SYNCS_PER_WINDOW_RST;

        // Directed table, reset settings first
        add_word(32'h0000_0000);            // ignored before alignment
        add_word(32'hFFFF_FF65);            // ignored
        add_word(32'hFFFF_FFE9);            // aligns, not counted
        add_word(32'h0000_00B5);
        add_word(32'h1234_56E8);
        add_word(32'hABCD_EFE8);            // 0350 hits its rate of 2
        add_word(32'h0000_0000);            // label zero counted
        add_word(32'hFFFF_FFFF);
        add_word(32'h5A5A_5AE9);            // first sync of the window
        add_close(32'hA5A5_A5E9, 16'd2);
        add_cfg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd1);
        add_close(32'h0000_00E9, 16'd1);
        add_cfg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd0);
        add_close(32'h0000_00E9, 16'd1);
        add_cfg(CFG_IDX_UNUSED, 8'h5A);     // no such register
        add_cfg(alrm_pkg::CFG_IDX_SYNC_LABEL, 8'h00); // table stays fixed
        add_word(32'h0000_00E9);
        add_close(32'h0000_0000, 16'd1);
        add_cfg(alrm_pkg::CFG_IDX_SYNC_LABEL, 8'hFF);
        add_cfg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd3);
        add_word(32'h0000_00FF);
        add_word(32'h0000_00FF);
        add_cfg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd1); // lowered below the open phase
        add_close(32'hFFFF_FFFF, 16'd0);
        add_cfg(alrm_pkg::CFG_IDX_SYNC_LABEL, 8'o351);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        prev_word = 1'b0;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                if (prev_word)
                    drain();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
                prev_word = 1'b0;
            end
            else
            begin
                send_word(dir_rows[i].word);
                if (dir_rows[i].typed && report_q.size() > 0)
                begin
                    b = report_q.pop_back();
                    b.report_label   = 8'o351;
                    b.observed_count = dir_rows[i].sync_obs;
                    b.expected_count = 6'd2;
                    b.rate_mismatch  = (dir_rows[i].sync_obs != 16'd2);
                    b.last_of_report = 1'b1;
                    report_q.push_back(b);
                end
                pace();
                prev_word = 1'b1;
            end
        end

        // Back-to-back burst with a sync every fourth word, sent while the receiver holds off
        rx_if.valid <= 1'b0;
        @(negedge clk);
        for (int i = 0; i < BURST_WORDS; i++)
        begin
            if ((i % 4) == 0)
                lbl = 8'o351;
            else
                lbl = WATCH_LBL[alrm_pkg::TABLE_IDX_BITS'($urandom_range(0,
                                alrm_pkg::TABLE_LEN - 1))];
            w = $urandom();
            w[7:0] = lbl;
            send_word(w);
        end

        // Random windows over several register settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    write_reg(alrm_pkg::CFG_IDX_SYNC_LABEL, 8'o351);
                    write_reg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd2);
                end
                1:
                begin
                    write_reg(alrm_pkg::CFG_IDX_SYNC_LABEL, 8'h00);
                    write_reg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd1);
                end
                2:
                begin
                    write_reg(alrm_pkg::CFG_IDX_SYNC_LABEL, 8'hFF);
                    write_reg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd4);
                end
                3:
                begin
                    write_reg(alrm_pkg::CFG_IDX_SYNC_LABEL, 8'($urandom_range(0, 255)));
                    write_reg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd255);
                end
                4:
                begin
                    write_reg(alrm_pkg::CFG_IDX_SYNC_LABEL, 8'($urandom_range(0, 255)));
                    write_reg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd3);
                end
                default:
                begin
                    write_reg(alrm_pkg::CFG_IDX_SYNC_LABEL, 8'o351);
                    write_reg(alrm_pkg::CFG_IDX_SYNCS_PER_WINDOW, 8'd0);
                end
            endcase
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    lbl = cur_sync;
                else if (r < 55)
                    lbl = WATCH_LBL[alrm_pkg::TABLE_IDX_BITS'($urandom_range(0,
                                    alrm_pkg::TABLE_LEN - 1))];
                else
                    lbl = 8'($urandom_range(0, 255));
                w = $urandom();
                w[7:0] = lbl;
                send_word(w);
                pace();
            end
        end

        drain();
        if (bad_beats == 0 && report_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
